FILE: sv/envod_pkg.sv
// envod_pkg: shared constants, register codes and the configuration struct
// for the envelope onset detector. Depends on nothing.
package envod_pkg;

    // default widths of the sample and timestamp fields
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;

    // fixed field widths
    localparam int GAIN_W   = 16;
    localparam int THRESH_W = 15;
    localparam int COUNT_W  = 16;
    localparam int FRAC_W   = 16;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // register reset values
    localparam logic [GAIN_W-1:0]   ATTACK_GAIN_RST     = 16'd19661;
    localparam logic [GAIN_W-1:0]   RELEASE_GAIN_RST    = 16'd131;
    localparam logic [THRESH_W-1:0] ONSET_THRESHOLD_RST = 15'd1638;
    localparam logic [COUNT_W-1:0]  QUIET_RUN_MIN_RST   = 16'd4800;

    // register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_ATTACK_GAIN     = 2'd0,
        REG_RELEASE_GAIN    = 2'd1,
        REG_ONSET_THRESHOLD = 2'd2,
        REG_QUIET_RUN_MIN   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   attack_gain;
        logic [GAIN_W-1:0]   release_gain;
        logic [THRESH_W-1:0] onset_threshold;
        logic [COUNT_W-1:0]  quiet_run_min;
    } cfg_t;

endpackage

FILE: sv/envod_apb_regs.sv
// envod_apb_regs: configuration registers behind an apb-style port.
// Depends on envod_pkg.
module envod_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [envod_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [envod_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [envod_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output envod_pkg::cfg_t                    cfg
);

    envod_pkg::cfg_t     cfg_reg;
    envod_pkg::reg_idx_t idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = envod_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_gain     <= envod_pkg::ATTACK_GAIN_RST;
            cfg_reg.release_gain    <= envod_pkg::RELEASE_GAIN_RST;
            cfg_reg.onset_threshold <= envod_pkg::ONSET_THRESHOLD_RST;
            cfg_reg.quiet_run_min   <= envod_pkg::QUIET_RUN_MIN_RST;
        end else if (wr_en) begin
            case (idx)
                envod_pkg::REG_ATTACK_GAIN: begin
                    cfg_reg.attack_gain <= pwdata[envod_pkg::GAIN_W-1:0];
                end
                envod_pkg::REG_RELEASE_GAIN: begin
                    cfg_reg.release_gain <= pwdata[envod_pkg::GAIN_W-1:0];
                end
                envod_pkg::REG_ONSET_THRESHOLD: begin
                    cfg_reg.onset_threshold <= pwdata[envod_pkg::THRESH_W-1:0];
                end
                envod_pkg::REG_QUIET_RUN_MIN: begin
                    cfg_reg.quiet_run_min <= pwdata[envod_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            envod_pkg::REG_ATTACK_GAIN: begin
                prdata = envod_pkg::APB_DATA_W'(cfg_reg.attack_gain);
            end
            envod_pkg::REG_RELEASE_GAIN: begin
                prdata = envod_pkg::APB_DATA_W'(cfg_reg.release_gain);
            end
            envod_pkg::REG_ONSET_THRESHOLD: begin
                prdata = envod_pkg::APB_DATA_W'(cfg_reg.onset_threshold);
            end
            envod_pkg::REG_QUIET_RUN_MIN: begin
                prdata = envod_pkg::APB_DATA_W'(cfg_reg.quiet_run_min);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

FILE: sv/envod_env_core.sv
// envod_env_core: magnitude, attack/release envelope, quiet-run counter and
// onset decision for one sample per step. Depends on envod_pkg.
module envod_env_core #(
    parameter int SAMPLE_BITS = envod_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   silent,
    input  envod_pkg::cfg_t        cfg,
    output logic                   onset
);

    localparam int ENV_W = SAMPLE_BITS - 1 + envod_pkg::FRAC_W;
    localparam int D_W   = ENV_W + 1;
    localparam int P_W   = D_W + envod_pkg::GAIN_W + 1;
    localparam int THR_W = envod_pkg::THRESH_W + envod_pkg::FRAC_W;
    localparam int CMP_W = (ENV_W > THR_W) ? ENV_W : THR_W;

    logic [ENV_W-1:0]              env_reg, env_next;
    logic [envod_pkg::COUNT_W-1:0] quiet_reg, quiet_next;

    logic [SAMPLE_BITS-1:0]    raw_mag;
    logic [SAMPLE_BITS-2:0]    mag;
    logic [ENV_W-1:0]          target;
    logic                      rising;
    logic [envod_pkg::GAIN_W-1:0] gain;
    logic signed [D_W-1:0]     diff;
    logic signed [P_W-1:0]     prod;
    logic [D_W-1:0]            step_amt;
    logic [D_W:0]              env_sum;
    logic [CMP_W-1:0]          env_cmp, thr_cmp;
    logic                      loud;

    // two's complement magnitude; the most negative code saturates
    assign raw_mag = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign mag     = silent ? '0 :
                     (raw_mag[SAMPLE_BITS-1] ? '1 : raw_mag[SAMPLE_BITS-2:0]);
    assign target  = {mag, {envod_pkg::FRAC_W{1'b0}}};

    assign rising = target > env_reg;
    assign gain   = rising ? cfg.attack_gain : cfg.release_gain;
    assign diff   = $signed({1'b0, target}) - $signed({1'b0, env_reg});
    assign prod   = $signed({1'b0, gain}) * diff;

    // arithmetic shift floors toward minus infinity; gain below one keeps
    // the scaled step inside the width of the difference
    assign step_amt = prod[envod_pkg::FRAC_W +: D_W];
    // gain below one keeps the sum between the old level and the target
    assign env_sum  = {2'b00, env_reg} + {step_amt[D_W-1], step_amt};
    assign env_next = env_sum[ENV_W-1:0];

    assign env_cmp = CMP_W'(env_next);
    assign thr_cmp = CMP_W'({cfg.onset_threshold, {envod_pkg::FRAC_W{1'b0}}});
    assign loud    = env_cmp > thr_cmp;
    assign onset   = loud && (quiet_reg >= cfg.quiet_run_min);

    always_comb begin
        if (loud) begin
            quiet_next = '0;
        end else if (quiet_reg != '1) begin
            quiet_next = quiet_reg + envod_pkg::COUNT_W'(1);
        end else begin
            quiet_next = quiet_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg   <= '0;
            quiet_reg <= '0;
        end else if (step) begin
            env_reg   <= env_next;
            quiet_reg <= quiet_next;
        end
    end

endmodule

FILE: sv/envelope_onset_detector.sv
// envelope_onset_detector: top level with input word register, envelope core,
// result register and configuration port. Depends on envod_pkg,
// envod_apb_regs and envod_env_core.
//
// Takes one audio word per clock and reports onsets. Each word carries a
// signed Q15 sample, a silent flag and a timestamp; the magnitude (zero when
// silent, saturated to the largest positive code) drives an attack/release
// envelope in Q15.16. When the envelope rises above onset_threshold after at
// least quiet_run_min quiet words, the word's timestamp comes out on the
// m_ side; most words produce no result. Throughput is one word per clock
// unless m_tready stalls: the envelope update (one 17 x 32 multiply and add)
// closes its feedback loop combinationally. m_tvalid comes from the result
// register, which is loaded from the input word register that accepted the
// word on the s_ side. Backpressure on m_tready stalls the input register
// and, through it, s_tready. Reset is synchronous
// on aresetn and clears the envelope, quiet count and registers to their
// documented defaults. Registers sit at byte addresses 0 (attack_gain),
// 4 (release_gain), 8 (onset_threshold) and 12 (quiet_run_min), and should
// only be written while no words are in flight.
module envelope_onset_detector #(
    parameter int SAMPLE_BITS = envod_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = envod_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input word stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample [SAMPLE_BITS-1:0], sample_time [SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS]
    input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // silent
    input  logic                              s_tuser,
    // onset stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // onset_time [TIME_BITS-1:0]
    output logic [((TIME_BITS+7)/8)*8-1:0]    m_tdata,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [envod_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [envod_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [envod_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int M_TDATA_W = ((TIME_BITS + 7) / 8) * 8;

    envod_pkg::cfg_t cfg;

    // input word register
    logic                   in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_silent_reg;
    logic [TIME_BITS-1:0]   in_time_reg;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic [TIME_BITS-1:0]   out_time_reg;

    logic s_accept;
    logic advance;
    logic process;
    logic onset;

    envod_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    envod_env_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (process),
        .sample  (in_sample_reg),
        .silent  (in_silent_reg),
        .cfg     (cfg),
        .onset   (onset)
    );

    // result slot is free when empty or being taken this cycle
    assign advance  = !m_valid_reg || m_tready;
    // input register takes a new word whenever its current one moves on
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    // the buffered word is evaluated and the envelope stepped
    assign process  = in_valid_reg && advance;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        if (process) begin
            m_valid_next = onset;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_silent_reg <= s_tuser;
            in_time_reg   <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
        end
        if (process && onset) begin
            out_time_reg <= in_time_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_time_reg);

endmodule
